// ----- sv/xmodem_receiver_control_assert.svh -----
// ----------------------------------------------------------------------------
// XMODEM receiver control assertion macros
// Concurrent assertion wrappers shared by the receiver control modules.
// ----------------------------------------------------------------------------
`ifndef XMODEM_RECEIVER_CONTROL_ASSERT_SVH
`define XMODEM_RECEIVER_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk while arst_n is high.
`define XMRC_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("xmrc assertion failed");

// Checked on every rising edge of clk, reset or not.
`define XMRC_ASSERT_ALWAYS(name, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("xmrc assertion failed");

`else

`define XMRC_ASSERT(name, prop)
`define XMRC_ASSERT_ALWAYS(name, prop)

`endif

`endif

// ----- sv/xmrc_pkg.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver control package
// Opcodes, protocol characters, phase codes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package xmrc_pkg;

	// Input opcodes.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Protocol characters.
	localparam logic [7:0] CH_SOH  = 8'h01;
	localparam logic [7:0] CH_STX  = 8'h02;
	localparam logic [7:0] CH_EOT  = 8'h04;
	localparam logic [7:0] CH_ACK  = 8'h06;
	localparam logic [7:0] CH_CAN  = 8'h18;
	localparam logic [7:0] CH_POLL = 8'h43;

	// Session phases.
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_POLL   = 2'd1;
	localparam logic [1:0] PH_PACKET = 2'd2;

	// End status codes.
	localparam logic [1:0] ST_RUNNING   = 2'd0;
	localparam logic [1:0] ST_EOT       = 2'd1;
	localparam logic [1:0] ST_CANCELLED = 2'd2;
	localparam logic [1:0] ST_TIMEOUT   = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RETRIES = 2'd1;
	localparam logic [1:0] REG_BASE    = 2'd2;

	// Register reset values.
	localparam logic [15:0] TIMEOUT_RST = 16'd1000;
	localparam logic [6:0]  RETRIES_RST = 7'd64;
	localparam logic [23:0] BASE_RST    = 24'h000400;

	// Packet layout: two number bytes, the data, then two CRC bytes.
	localparam logic [10:0] SMALL_DATA_END = 11'd130;
	localparam logic [10:0] LARGE_DATA_END = 11'd1026;
	localparam logic [10:0] SMALL_LAST     = 11'd131;
	localparam logic [10:0] LARGE_LAST     = 11'd1027;
	localparam logic [10:0] DATA_START     = 11'd2;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        wr_valid;
		logic [23:0] wr_address;
		logic [7:0]  wr_data;
		logic        done_res;
		logic [1:0]  end_status;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/xmodem_receiver_control.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver control
// Receive side of an XMODEM-1K/CRC session: polls with 'C', strips packet
// framing, emits flash writes for data bytes and acknowledges packets.
// ----------------------------------------------------------------------------
// Each input word (start, received byte or millisecond tick) yields exactly
// one result word, held in a result register; a new word can be taken every
// cycle while in_stall is low. The result register is backed by a one-word
// skid stage, so in_stall rises only once two results are waiting on a
// stalled output. Configuration writes take effect on the next cycle and
// should be made only while the block is idle.
`default_nettype none

module xmodem_receiver_control (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   opcode,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              tx_valid,
	output logic [7:0]        tx_byte,
	output logic              wr_valid,
	output logic [23:0]       wr_address,
	output logic [7:0]        wr_data,
	output logic              done_res,
	output logic [1:0]        end_status
);
	import xmrc_pkg::*;

	logic  fire;
	logic  full;
	res_t  res;
	res_t  out_data;

	assign in_stall = full;
	assign fire     = in_valid && !full;

	xmrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.opcode    (opcode),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res)
	);

	xmrc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign tx_valid   = out_data.tx_valid;
	assign tx_byte    = out_data.tx_byte;
	assign wr_valid   = out_data.wr_valid;
	assign wr_address = out_data.wr_address;
	assign wr_data    = out_data.wr_data;
	assign done_res   = out_data.done_res;
	assign end_status = out_data.end_status;

endmodule

`default_nettype wire

// ----- sv/xmrc_core.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver control core
// Configuration registers, session state and the next-state logic that turns
// one accepted word into one result word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xmodem_receiver_control_assert.svh"

module xmrc_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire logic [1:0]   opcode,
	input  wire logic [7:0]   rx_byte,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	output xmrc_pkg::res_t    res
);
	import xmrc_pkg::*;

	logic [15:0] timeout_q;
	logic [6:0]  retries_q;
	logic [23:0] base_q;

	logic [1:0]  phase_q, phase_d;
	logic [6:0]  attempt_q, attempt_d;
	logic [15:0] wait_q, wait_d;
	logic [10:0] pos_q, pos_d;
	logic        large_q, large_d;
	logic        send_poll_q, send_poll_d;
	logic [23:0] addr_q, addr_d;

	logic [16:0] wait_inc;
	logic        expired;
	logic [6:0]  attempt_inc;
	logic        retries_out;
	logic [10:0] data_end;
	logic [10:0] last_pos;
	logic [7:0]  pkt_data;
	logic        poll_fail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			retries_q <= RETRIES_RST;
			base_q    <= BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data[15:0];
				REG_RETRIES: retries_q <= cfg_data[6:0];
				REG_BASE:    base_q    <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_comb begin
		wait_inc    = {1'b0, wait_q} + 17'd1;
		// A timeout of zero behaves as one: the compare is always true.
		expired     = (wait_inc >= {1'b0, timeout_q});
		attempt_inc = attempt_q + 7'd1;
		retries_out = (attempt_inc >= retries_q);
		data_end    = large_q ? LARGE_DATA_END : SMALL_DATA_END;
		last_pos    = large_q ? LARGE_LAST : SMALL_LAST;
		// A byte that timed out inside a packet is taken as zero.
		pkt_data    = (opcode == OP_BYTE) ? rx_byte : 8'h00;
		poll_fail   = 1'b0;

		res         = '0;
		phase_d     = phase_q;
		attempt_d   = attempt_q;
		wait_d      = wait_q;
		pos_d       = pos_q;
		large_d     = large_q;
		send_poll_d = send_poll_q;
		addr_d      = addr_q;

		if (fire) begin
			case (opcode)
				OP_START: begin
					phase_d      = PH_POLL;
					attempt_d    = '0;
					wait_d       = '0;
					pos_d        = '0;
					large_d      = 1'b0;
					send_poll_d  = 1'b1;
					addr_d       = base_q;
					res.tx_valid = 1'b1;
					res.tx_byte  = CH_POLL;
				end
				OP_BYTE, OP_TICK: begin
					case (phase_q)
						PH_POLL: begin
							if (opcode == OP_BYTE) begin
								if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
									large_d     = (rx_byte == CH_STX);
									send_poll_d = 1'b0;
									pos_d       = '0;
									wait_d      = '0;
									phase_d     = PH_PACKET;
								end else if (rx_byte == CH_EOT) begin
									res.tx_valid   = 1'b1;
									res.tx_byte    = CH_ACK;
									res.done_res   = 1'b1;
									res.end_status = ST_EOT;
									phase_d        = PH_IDLE;
								end else if (rx_byte == CH_CAN) begin
									res.done_res   = 1'b1;
									res.end_status = ST_CANCELLED;
									phase_d        = PH_IDLE;
								end else begin
									poll_fail = 1'b1;
								end
							end else if (expired) begin
								poll_fail = 1'b1;
							end else begin
								wait_d = wait_inc[15:0];
							end
							if (poll_fail) begin
								attempt_d = attempt_inc;
								wait_d    = '0;
								if (retries_out) begin
									res.done_res   = 1'b1;
									res.end_status = ST_TIMEOUT;
									phase_d        = PH_IDLE;
								end else if (send_poll_q) begin
									res.tx_valid = 1'b1;
									res.tx_byte  = CH_POLL;
								end
							end
						end
						PH_PACKET: begin
							if (opcode == OP_BYTE || expired) begin
								wait_d = '0;
								if (pos_q >= DATA_START && pos_q < data_end) begin
									res.wr_valid   = 1'b1;
									res.wr_address = addr_q;
									res.wr_data    = pkt_data;
									addr_d         = addr_q + 24'd1;
								end
								if (pos_q >= last_pos) begin
									res.tx_valid = 1'b1;
									res.tx_byte  = CH_ACK;
									phase_d      = PH_POLL;
									attempt_d    = '0;
									pos_d        = '0;
								end else begin
									pos_d = pos_q + 11'd1;
								end
							end else begin
								wait_d = wait_inc[15:0];
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			attempt_q   <= '0;
			wait_q      <= '0;
			pos_q       <= '0;
			large_q     <= 1'b0;
			send_poll_q <= 1'b1;
			addr_q      <= BASE_RST;
		end else begin
			phase_q     <= phase_d;
			attempt_q   <= attempt_d;
			wait_q      <= wait_d;
			pos_q       <= pos_d;
			large_q     <= large_d;
			send_poll_q <= send_poll_d;
			addr_q      <= addr_d;
		end
	end

	// A word that ends the session leaves the block idle.
	`XMRC_ASSERT(a_done_goes_idle, fire && res.done_res |=> phase_q == PH_IDLE)
	// Once a header has been seen, polling with 'C' stays off.
	`XMRC_ASSERT_ALWAYS(a_packet_silent, phase_q == PH_PACKET |-> !send_poll_q)
	// The packet position never runs past the last CRC byte.
	`XMRC_ASSERT(a_pos_bound, pos_q <= LARGE_LAST)

endmodule

`default_nettype wire

// ----- sv/xmrc_obuf.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver control output buffer
// Result register with a skid stage, so a word can be taken while the
// previous result still waits on a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xmodem_receiver_control_assert.svh"

module xmrc_obuf (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  xmrc_pkg::res_t    push_data,
	output logic              full,
	output logic              out_valid,
	input  wire logic         out_stall,
	output xmrc_pkg::res_t    out_data
);
	import xmrc_pkg::*;

	logic  main_valid_q;
	logic  skid_valid_q;
	res_t  main_q;
	res_t  skid_q;
	logic  pop;
	logic  to_main;
	logic  to_skid;

	assign pop     = main_valid_q && !out_stall;
	assign to_main = skid_valid_q ? pop : (push && (!main_valid_q || pop));
	assign to_skid = push && !skid_valid_q && main_valid_q && !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (to_skid) begin
				skid_valid_q <= 1'b1;
			end
			if (to_main) begin
				main_valid_q <= 1'b1;
			end else if (pop) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (to_main) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end
		if (to_skid) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// The skid stage only holds a word behind a waiting result.
	`XMRC_ASSERT_ALWAYS(a_skid_behind_main, skid_valid_q |-> main_valid_q)
	// A word pushed behind a stalled result lands in the skid stage.
	`XMRC_ASSERT(a_skid_fill, push && main_valid_q && out_stall |=> skid_valid_q)
	// Draining the skid stage refills the result register.
	`XMRC_ASSERT(a_skid_drain, skid_valid_q && !out_stall |=> main_valid_q && !skid_valid_q)

endmodule

`default_nettype wire

// ----- bench/tb_xmodem_receiver_control.sv -----
// ----------------------------------------------------------------------------
// XMODEM receiver control testbench
// Drives start commands, received bytes and millisecond ticks through the
// valid/stall input channel. Every accepted word is run through a local
// model of the session, and each result word is checked against it field by
// field. A short table of directed words comes first. Random sessions
// follow under several register settings, with bursty input and a stalling
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_xmodem_receiver_control;

	import xmrc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DIR_N = 28;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [0:0] {ROW_WORD, ROW_CFG} row_t;
	typedef enum logic [2:0] {
		EXP_PRED, EXP_ZERO, EXP_POLL, EXP_EOT, EXP_CANCEL, EXP_TIMEOUT
	} want_t;

	typedef struct packed {
		row_t        kind;
		logic [1:0]  op;
		logic [7:0]  b;
		want_t       want;
		logic [15:0] t;
		logic [6:0]  r;
		logic [23:0] a;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_TICK;
	logic [7:0]  rx_byte = 8'h00;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_TIMEOUT;
	logic [23:0] cfg_data = 24'h0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        wr_valid;
	logic [23:0] wr_address;
	logic [7:0]  wr_data;
	logic        done_res;
	logic [1:0]  end_status;

	xmodem_receiver_control dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.rx_byte    (rx_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.wr_valid   (wr_valid),
		.wr_address (wr_address),
		.wr_data    (wr_data),
		.done_res   (done_res),
		.end_status (end_status)
	);

	// Register copies and session state of the model.
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	logic [6:0]  cfg_retries = RETRIES_RST;
	logic [23:0] cfg_base = BASE_RST;
	logic [1:0]  ses_phase = PH_IDLE;
	logic [6:0]  try_count = '0;
	logic [15:0] wait_cnt = '0;
	logic [10:0] pkt_pos = '0;
	logic        big_pkt = 1'b0;
	logic        poll_with_c = 1'b1;
	logic [23:0] wr_ptr = BASE_RST;

	res_t     pending_words[$];
	dir_row_t dir_tab [DIR_N];
	int       err_count = 0;
	int       words_sent = 0;
	int       words_seen = 0;
	int       burst_left = 0;
	bit       hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	// ---------------- session model ----------------

	function automatic void finish_session(inout res_t r, input logic [1:0] status);
		r.done_res = 1'b1;
		r.end_status = status;
		ses_phase = PH_IDLE;
	endfunction

	function automatic void try_failed(inout res_t r);
		try_count = try_count + 7'd1;
		wait_cnt = '0;
		if (try_count >= cfg_retries) begin
			finish_session(r, ST_TIMEOUT);
		end else if (poll_with_c) begin
			r.tx_valid = 1'b1;
			r.tx_byte = CH_POLL;
		end
	endfunction

	// One packet byte; a byte that timed out arrives here as zero.
	function automatic void take_packet_byte(inout res_t r, input logic [7:0] b);
		int sz;
		int p;
		sz = big_pkt ? 1024 : 128;
		p = pkt_pos;
		wait_cnt = '0;
		if (p >= 2 && p < sz + 2) begin
			r.wr_valid = 1'b1;
			r.wr_address = wr_ptr;
			r.wr_data = b;
			wr_ptr = wr_ptr + 24'd1;
		end
		if (p >= sz + 3) begin
			r.tx_valid = 1'b1;
			r.tx_byte = CH_ACK;
			ses_phase = PH_POLL;
			try_count = '0;
			pkt_pos = '0;
		end else begin
			pkt_pos = 11'(p + 1);
		end
	endfunction

	function automatic bit tick_runs_out();
		logic [16:0] w;
		w = {1'b0, wait_cnt} + 17'd1;
		if (w >= {1'b0, cfg_timeout}) begin
			wait_cnt = '0;
			return 1'b1;
		end
		wait_cnt = w[15:0];
		return 1'b0;
	endfunction

	function automatic res_t xmodem_predict(logic [1:0] op, logic [7:0] b);
		res_t r;
		r = '0;
		if (op == OP_START) begin
			ses_phase = PH_POLL;
			try_count = '0;
			wait_cnt = '0;
			pkt_pos = '0;
			big_pkt = 1'b0;
			poll_with_c = 1'b1;
			wr_ptr = cfg_base;
			r.tx_valid = 1'b1;
			r.tx_byte = CH_POLL;
		end else if (op == OP_UNUSED) begin
			r = '0;
		end else if (ses_phase == PH_POLL) begin
			if (op == OP_BYTE) begin
				if (b == CH_SOH || b == CH_STX) begin
					big_pkt = (b == CH_STX);
					poll_with_c = 1'b0;
					pkt_pos = '0;
					wait_cnt = '0;
					ses_phase = PH_PACKET;
				end else if (b == CH_EOT) begin
					r.tx_valid = 1'b1;
					r.tx_byte = CH_ACK;
					finish_session(r, ST_EOT);
				end else if (b == CH_CAN) begin
					finish_session(r, ST_CANCELLED);
				end else begin
					try_failed(r);
				end
			end else if (tick_runs_out()) begin
				try_failed(r);
			end
		end else if (ses_phase == PH_PACKET) begin
			if (op == OP_BYTE)
				take_packet_byte(r, b);
			else if (tick_runs_out())
				take_packet_byte(r, 8'h00);
		end
		return r;
	endfunction

	// ---------------- stimulus ----------------

	// Offers one word and waits for it to be taken; the sender works in bursts.
	task automatic send_word(input logic [1:0] op, input logic [7:0] b, input want_t want);
		int gap;
		res_t guess;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		opcode <= op;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		guess = xmodem_predict(op, b);
		if (want != EXP_PRED)
			guess = '0;
		case (want)
			EXP_POLL: begin
				guess.tx_valid = 1'b1;
				guess.tx_byte = CH_POLL;
			end
			EXP_EOT: begin
				guess.tx_valid = 1'b1;
				guess.tx_byte = CH_ACK;
				guess.done_res = 1'b1;
				guess.end_status = ST_EOT;
			end
			EXP_CANCEL: begin
				guess.done_res = 1'b1;
				guess.end_status = ST_CANCELLED;
			end
			EXP_TIMEOUT: begin
				guess.done_res = 1'b1;
				guess.end_status = ST_TIMEOUT;
			end
			default: ;
		endcase
		pending_words.push_back(guess);
		words_sent++;
	endtask

	// Stops offering words until every expected result has come out.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_config(input logic [15:0] t, input logic [6:0] r,
			input logic [23:0] a);
		logic [23:0] junk;
		junk = 24'($urandom);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_TIMEOUT;
		cfg_data <= {junk[23:16], t};
		@(negedge clk);
		cfg_index <= REG_RETRIES;
		cfg_data <= {junk[23:7], r};
		@(negedge clk);
		cfg_index <= REG_BASE;
		cfg_data <= a;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_timeout = t;
		cfg_retries = r;
		cfg_base = a;
		repeat (2) @(negedge clk);
	endtask

	// ---------------- result side ----------------

	task automatic report_mismatch(input string what);
		err_count++;
		$display("mismatch: %s", what);
	endtask

	task automatic check_field(input string name, input logic [23:0] got,
			input logic [23:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %0d %s got %0h expected %0h",
				words_seen, name, got, want));
	endtask

	// The receiver stalls on a randomly chosen pattern, picked anew at the end of each random span.
	initial begin
		int mode;
		int span;
		int hold_left;
		mode = 0;
		span = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				span = $urandom_range(16, 96);
				mode = $urandom_range(0, 3);
			end
			span--;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (span % 5 < 2);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word %0d came with nothing expected", words_seen));
			end else begin
				want = pending_words.pop_front();
				check_field("tx_valid", 24'(tx_valid), 24'(want.tx_valid));
				check_field("tx_byte", 24'(tx_byte), 24'(want.tx_byte));
				check_field("wr_valid", 24'(wr_valid), 24'(want.wr_valid));
				check_field("wr_address", wr_address, want.wr_address);
				check_field("wr_data", 24'(wr_data), 24'(want.wr_data));
				check_field("done_res", 24'(done_res), 24'(want.done_res));
				check_field("end_status", 24'(end_status), 24'(want.end_status));
			end
			words_seen++;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int tries;
		int n;
		int goal;
		logic [15:0] t;
		logic [6:0]  r;
		logic [23:0] a;
		logic [7:0]  hdr;

		dir_tab = '{
			'{ROW_WORD, OP_BYTE,   CH_POLL, EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_UNUSED, 8'hFF,   EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_START,  8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   CH_STX,  EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'h01,   EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'hFE,   EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'hFF,   EXP_PRED,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'h00,   EXP_PRED,    16'd0, 7'd0, 24'h0},
			// A start in the middle of a packet restarts the session.
			'{ROW_WORD, OP_START,  8'hFF,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   CH_CAN,  EXP_CANCEL,  16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_START,  8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   CH_EOT,  EXP_EOT,     16'd0, 7'd0, 24'h0},
			'{ROW_CFG,  OP_TICK,   8'h00,   EXP_PRED,    16'd1, 7'd1, 24'hFFFFFF},
			'{ROW_WORD, OP_START,  8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_TICK,   8'h00,   EXP_TIMEOUT, 16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_START,  8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   CH_SOH,  EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'h01,   EXP_ZERO,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'hFE,   EXP_ZERO,    16'd0, 7'd0, 24'h0},
			// The first two data bytes straddle the top of the address space.
			'{ROW_WORD, OP_BYTE,   8'hA5,   EXP_PRED,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'h5A,   EXP_PRED,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_TICK,   8'h00,   EXP_PRED,    16'd0, 7'd0, 24'h0},
			'{ROW_CFG,  OP_TICK,   8'h00,   EXP_PRED,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_START,  8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_BYTE,   8'h7F,   EXP_TIMEOUT, 16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_START,  8'h00,   EXP_POLL,    16'd0, 7'd0, 24'h0},
			'{ROW_WORD, OP_TICK,   8'h00,   EXP_TIMEOUT, 16'd0, 7'd0, 24'h0}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_N; k++) begin
			if (dir_tab[k].kind == ROW_CFG)
				load_config(dir_tab[k].t, dir_tab[k].r, dir_tab[k].a);
			else
				send_word(dir_tab[k].op, dir_tab[k].b, dir_tab[k].want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					t = 16'($urandom_range(2, 5));
					r = 7'($urandom_range(3, 8));
					a = 24'($urandom);
				end
				1: begin
					t = 16'd1;
					r = 7'd127;
					a = 24'hFFFF00;
				end
				2: begin
					t = 16'hFFFF;
					r = 7'd1;
					a = 24'h000000;
				end
				default: begin
					t = 16'($urandom_range(1, 4));
					r = 7'($urandom_range(1, 4));
					a = 24'($urandom);
				end
			endcase
			load_config(t, r, a);
			// Hold the output off long enough for the block to back up.
			if (ph == 0)
				hold_req = 1'b1;
			// Each setting gets about ninety words; a packet still in progress is cut off
			// once the count runs fifty words past the budget.
			goal = words_sent + 90;
			while (words_sent < goal) begin
				send_word(OP_START, 8'($urandom), EXP_PRED);
				tries = $urandom_range(1, 4);
				repeat (tries) begin
					if (words_sent >= goal)
						break;
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: begin
							hdr = ($urandom_range(0, 9) == 0) ? CH_STX : CH_SOH;
							send_word(OP_BYTE, hdr, EXP_PRED);
							n = (hdr == CH_STX ? 1024 : 128) + 4;
							for (int i = 0; i < n; i++) begin
								if (words_sent >= goal + 50)
									break;
								if ($urandom_range(0, 39) == 0)
									repeat ($urandom_range(1, 4))
										send_word(OP_TICK, 8'($urandom), EXP_PRED);
								if ($urandom_range(0, 199) == 0)
									break;
								send_word(OP_BYTE, 8'($urandom), EXP_PRED);
							end
						end
						6: send_word(($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_BYTE,
							8'($urandom), EXP_PRED);
						default: repeat ((cfg_timeout > 8) ? 8 : cfg_timeout + 1)
							send_word(OP_TICK, 8'($urandom), EXP_PRED);
					endcase
				end
				case ($urandom_range(0, 3))
					0: send_word(OP_BYTE, CH_EOT, EXP_PRED);
					1: send_word(OP_BYTE, CH_CAN, EXP_PRED);
					2: send_word(OP_TICK, 8'($urandom), EXP_PRED);
					default: ;
				endcase
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
